### rtl/kmp_pkg.sv
package kmp_pkg;

    localparam int MAX_PATTERN_DEF = 64;
    localparam int POS_WIDTH_DEF   = 32;
    localparam int END_WIDTH       = 32;

    localparam logic [1:0] KIND_PATTERN = 2'd0;
    localparam logic [1:0] KIND_TEXT    = 2'd1;
    localparam logic [1:0] KIND_CLEAR   = 2'd2;
    localparam logic [1:0] KIND_RESTART = 2'd3;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] char_value;
    } t_in_item;

    typedef struct packed {
        logic                 match;
        logic [END_WIDTH-1:0] end_position;
        logic                 status;
    } t_out_item;

    typedef struct packed {
        logic load;
        logic step;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic need_walk;
        logic hit;
        logic j_zero;
        logic out_free;
    } t_stat;

endpackage

### rtl/kmp_ctrl.sv
module kmp_ctrl
    import kmp_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_CMP,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_ready;
    logic   n_ready;

    always_comb begin
        n_state      = r_state;
        o_cmd.load   = 1'b0;
        o_cmd.step   = 1'b0;
        o_cmd.finish = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && r_ready) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_stat.need_walk ? S_READ : S_DONE;
                end
            end
            S_READ: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                o_cmd.step = 1'b1;
                n_state    = (i_stat.hit || i_stat.j_zero) ? S_DONE : S_READ;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_ready = (n_state == S_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ready <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ready <= n_ready;
        end
    end

    assign o_in_ready = r_ready;

endmodule

### rtl/kmp_datapath.sv
module kmp_datapath
    import kmp_pkg::*;
#(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF,
    parameter int POS_WIDTH   = POS_WIDTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_item  i_in,
    input  t_cmd      i_cmd,
    output t_stat     o_stat,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out
);

    localparam int LW = $clog2(MAX_PATTERN + 1);
    localparam int AW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

    logic [7:0]  pattern_store [MAX_PATTERN];
    logic [LW-1:0] failure_links [MAX_PATTERN];

    logic [LW-1:0]        r_plen;
    logic [LW-1:0]        r_build;
    logic [LW-1:0]        r_match;
    logic [POS_WIDTH-1:0] r_pos;
    logic [LW-1:0]        r_j;
    logic [1:0]           r_kind;
    logic [7:0]           r_c;
    logic [7:0]           r_pat_q;
    logic [LW-1:0]        r_link_q;
    logic                 r_out_valid;
    t_out_item            r_out;

    logic [LW-1:0]        n_j;
    logic [LW-1:0]        start_j;
    logic [LW-1:0]        link_j;
    logic [POS_WIDTH-1:0] n_pos;
    logic                 full;
    logic                 full_match;
    logic [AW-1:0]        pat_addr;
    logic [AW-1:0]        link_addr;
    logic [AW-1:0]        wr_addr;
    t_out_item            n_out;

    assign full      = (r_plen >= LW'(MAX_PATTERN));
    assign pat_addr  = r_j[AW-1:0];
    assign link_addr = AW'(r_j - LW'(1));
    assign wr_addr   = r_plen[AW-1:0];

    always_comb begin
        start_j          = '0;
        o_stat.need_walk = 1'b0;
        unique case (i_in.kind)
            KIND_PATTERN: begin
                start_j          = (r_build >= r_plen) ? '0 : r_build;
                o_stat.need_walk = (r_plen != '0) && !full;
            end
            KIND_TEXT: begin
                start_j          = (r_match >= r_plen) ? '0 : r_match;
                o_stat.need_walk = (r_plen != '0);
            end
            default: begin
                start_j = '0;
            end
        endcase
    end

    // one failure-link step
    assign o_stat.hit      = (r_pat_q == r_c);
    assign o_stat.j_zero   = (r_j == '0);
    assign o_stat.out_free = !r_out_valid || i_out_ready;
    assign link_j          = (r_link_q < r_j) ? r_link_q : '0;

    always_comb begin
        if (o_stat.hit) begin
            n_j = r_j + LW'(1);
        end else if (o_stat.j_zero) begin
            n_j = '0;
        end else begin
            n_j = link_j;
        end
    end

    assign n_pos      = (r_pos == '1) ? r_pos : r_pos + POS_WIDTH'(1);
    assign full_match = (r_plen == '0) || (r_j >= r_plen);

    always_comb begin
        n_out.match        = 1'b0;
        n_out.end_position = '0;
        n_out.status       = 1'b0;
        unique case (r_kind)
            KIND_PATTERN: begin
                n_out.status = full;
            end
            KIND_TEXT: begin
                n_out.match        = full_match;
                n_out.end_position = END_WIDTH'(n_pos);
            end
            default: begin
                n_out.match = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_pat_q  <= pattern_store[pat_addr];
        r_link_q <= failure_links[link_addr];
        if (i_cmd.finish && (r_kind == KIND_PATTERN) && !full) begin
            pattern_store[wr_addr] <= r_c;
            failure_links[wr_addr] <= r_j;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= i_in.kind;
            r_c    <= i_in.char_value;
            r_j    <= start_j;
        end else if (i_cmd.step) begin
            r_j <= n_j;
        end
        if (i_cmd.finish) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plen      <= '0;
            r_build     <= '0;
            r_match     <= '0;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.finish) begin
                unique case (r_kind)
                    KIND_PATTERN: begin
                        if (!full) begin
                            r_build <= r_j;
                            r_plen  <= r_plen + LW'(1);
                        end
                    end
                    KIND_TEXT: begin
                        r_pos <= n_pos;
                        if (r_plen == '0) begin
                            r_match <= '0;
                        end else if (r_j >= r_plen) begin
                            // border of the full pattern is the last built link
                            r_match <= r_build;
                        end else begin
                            r_match <= r_j;
                        end
                    end
                    KIND_CLEAR: begin
                        r_plen  <= '0;
                        r_build <= '0;
                        r_match <= '0;
                        r_pos   <= '0;
                    end
                    KIND_RESTART: begin
                        r_match <= '0;
                        r_pos   <= '0;
                    end
                    default: begin
                        r_match <= r_match;
                    end
                endcase
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    a_finish_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |-> (!r_out_valid || i_out_ready))
        else $error("result written while output slot busy");

    a_finish_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |=> r_out_valid)
        else $error("finished item not presented");

    a_build_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_plen == '0 && r_build == '0) || (r_plen != '0 && r_build < r_plen))
        else $error("build prefix out of range");

    a_match_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_plen == '0 && r_match == '0) || (r_plen != '0 && r_match < r_plen))
        else $error("matched prefix out of range");

endmodule

### rtl/kmp_stream_matcher.sv
// Streaming KMP matcher.
// Input channel i_in_valid / o_in_ready carries t_in_item {kind, char_value}:
//   pattern byte, text byte, clear all, restart text.
// Output channel o_out_valid / i_out_ready carries one t_out_item per item:
//   match flag, 1-based text position (saturating), dropped-byte status.
// Pattern bytes build their failure links on arrival; text bytes walk the
// links and every completed occurrence is flagged, overlaps included.
// Timing: one item at a time. An item is taken in the idle state; each
// compare step is a registered read of the pattern and link memories
// (S_READ), then a compare (S_CMP). The result register is then written
// (S_DONE) and the block returns to idle, where the next item is taken. An
// item that needs no walk skips the compare steps; walks amortize to about
// two steps a byte. The result register frees the input side: the next
// item is accepted while a result still waits. If the receiver stalls,
// the following item finishes its walk and holds until the result
// register frees up.
// Reset clears pattern length, prefixes and text position; memory contents
// are left as they are and only entries below the pattern length are used.
module kmp_stream_matcher
    import kmp_pkg::*;
#(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF,
    parameter int POS_WIDTH   = POS_WIDTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out
);

    t_cmd  cmd;
    t_stat stat;

    kmp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    kmp_datapath #(
        .MAX_PATTERN (MAX_PATTERN),
        .POS_WIDTH   (POS_WIDTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule

### tb/kmp_stream_matcher_tb.sv
`timescale 1ns / 100ps

module kmp_stream_matcher_tb;
    import kmp_pkg::*;

    localparam int MAX_PAT     = MAX_PATTERN_DEF;
    localparam int HOLD_AT     = 400;
    localparam int HOLD_LEN    = 300;
    localparam int DRAIN_AT    = 1000;
    localparam int CALM_TAIL   = 250;
    localparam int TAIL_CYCLES = 200;
    localparam int STALL_LIMIT = 4000;
    localparam int RANDOM_ITEMS = 1950;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      o_in_ready;
    t_in_item  in_item = '0;
    logic      o_out_valid;
    logic      out_ready = 1'b0;
    t_out_item o_out;

    kmp_stream_matcher uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out       (o_out)
    );

    always #5 i_clk = ~i_clk;

    // matcher state as the block should hold it
    logic [7:0]  pat_mem  [MAX_PAT];
    logic [6:0]  link_mem [MAX_PAT];
    logic [6:0]  pat_len   = '0;
    logic [6:0]  build_len = '0;
    logic [6:0]  text_len  = '0;
    logic [31:0] text_pos  = '0;

    t_in_item  pending_items[$];
    t_out_item expected_results[$];
    t_in_item  next_item;
    t_out_item exp_res;
    t_out_item got_res;

    int items_sent     = 0;
    int results_checked = 0;
    int matches_seen   = 0;
    int drops_seen     = 0;
    int errors         = 0;
    int send_gap       = 0;
    int recv_gap       = 0;
    int hold_cycles    = 0;
    int idle_cycles    = 0;
    bit drain_pause    = 1'b0;
    bit drain_done     = 1'b0;
    bit long_hold_done = 1'b0;
    logic ready_next;

    function automatic logic [7:0] pat_byte(input logic [6:0] idx);
        return (idx < MAX_PAT) ? pat_mem[idx[5:0]] : 8'd0;
    endfunction

    function automatic logic [6:0] border_of(input logic [6:0] len);
        logic [6:0] v;
        if (len == 0 || len > MAX_PAT) return 7'd0;
        v = link_mem[6'(len - 7'd1)];
        return (v < len) ? v : 7'd0;
    endfunction

    function automatic logic [6:0] extend_prefix(input logic [6:0] j, input logic [7:0] c);
        logic [6:0] k;
        k = j;
        while (k != 0 && pat_byte(k) != c) k = border_of(k);
        if (pat_byte(k) == c) k = k + 1'b1;
        return k;
    endfunction

    function automatic t_out_item predict_item(input t_in_item it);
        t_out_item  r;
        logic [6:0] j;
        r = '0;
        case (it.kind)
            KIND_PATTERN: begin
                if (pat_len >= MAX_PAT) begin
                    r.status = 1'b1;
                end else begin
                    j = '0;
                    if (pat_len > 0) begin
                        j = (build_len >= pat_len) ? 7'd0 : build_len;
                        j = extend_prefix(j, it.char_value);
                        if (j >= pat_len + 1) j = '0;
                    end
                    pat_mem[pat_len[5:0]]  = it.char_value;
                    link_mem[pat_len[5:0]] = j;
                    build_len = j;
                    pat_len   = pat_len + 1'b1;
                end
            end
            KIND_TEXT: begin
                if (text_pos != '1) text_pos = text_pos + 1'b1;
                r.end_position = text_pos;
                if (pat_len == 0) begin
                    r.match  = 1'b1;
                    text_len = '0;
                end else begin
                    j = (text_len >= pat_len) ? 7'd0 : text_len;
                    j = extend_prefix(j, it.char_value);
                    if (j >= pat_len) begin
                        r.match = 1'b1;
                        j = border_of(pat_len);
                    end
                    text_len = j;
                end
            end
            KIND_CLEAR: begin
                pat_len   = '0;
                build_len = '0;
                text_len  = '0;
                text_pos  = '0;
            end
            default: begin
                text_len = '0;
                text_pos = '0;
            end
        endcase
        return r;
    endfunction

    function automatic bit idling_allowed();
        return pending_items.size() > CALM_TAIL && ((items_sent / 150) % 3 != 2);
    endfunction

    task automatic add_item(input logic [1:0] kind, input logic [7:0] c);
        t_in_item it;
        it.kind       = kind;
        it.char_value = c;
        pending_items.push_back(it);
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && o_in_ready) begin
                expected_results.push_back(predict_item(in_item));
                items_sent++;
                if (items_sent == DRAIN_AT && !drain_done) begin
                    drain_pause = 1'b1;
                    drain_done  = 1'b1;
                end
            end
            if (!in_valid || o_in_ready) begin
                if (drain_pause) begin
                    in_valid <= 1'b0;
                    if (expected_results.size() == 0) drain_pause = 1'b0;
                end else if (send_gap > 0) begin
                    in_valid <= 1'b0;
                    send_gap--;
                end else if (pending_items.size() > 0) begin
                    next_item = pending_items.pop_front();
                    in_valid <= 1'b1;
                    in_item  <= next_item;
                    if (idling_allowed() && $urandom_range(0, 7) == 0)
                        send_gap = $urandom_range(1, 16);
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (o_out_valid && out_ready) begin
                got_res = o_out;
                results_checked++;
                if (got_res.match)  matches_seen++;
                if (got_res.status) drops_seen++;
                if (expected_results.size() == 0) begin
                    $error("unexpected result: match %0d end_position %0d status %0d",
                           got_res.match, got_res.end_position, got_res.status);
                    errors++;
                end else begin
                    exp_res = expected_results.pop_front();
                    if (got_res.match !== exp_res.match) begin
                        $error("match: expected %0d, got %0d", exp_res.match, got_res.match);
                        errors++;
                    end
                    if (got_res.end_position !== exp_res.end_position) begin
                        $error("end_position: expected %0d, got %0d",
                               exp_res.end_position, got_res.end_position);
                        errors++;
                    end
                    if (got_res.status !== exp_res.status) begin
                        $error("status: expected %0d, got %0d", exp_res.status, got_res.status);
                        errors++;
                    end
                end
            end
            if (!long_hold_done && items_sent >= HOLD_AT) begin
                long_hold_done = 1'b1;
                hold_cycles    = HOLD_LEN;
            end
            if (hold_cycles > 0) begin
                hold_cycles--;
                ready_next = 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap--;
                ready_next = 1'b0;
            end else begin
                ready_next = 1'b1;
                if (idling_allowed() && $urandom_range(0, 7) == 0)
                    recv_gap = $urandom_range(1, 16);
            end
            out_ready <= ready_next;
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((in_valid && o_in_ready) || (o_out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("stalled for %0d cycles", idle_cycles);
                $display("** kmp_stream_matcher: FAILED **");
                $finish;
            end
        end
    end

    initial begin
        int          seq_kind;
        int          plen;
        int          tlen;
        int          alpha;
        int          n;
        logic [7:0]  base;

        // empty pattern matches everything
        add_item(KIND_TEXT, 8'h00);
        add_item(KIND_TEXT, 8'hFF);
        // overlapping hits on "aba"
        add_item(KIND_PATTERN, "a");
        add_item(KIND_PATTERN, "b");
        add_item(KIND_PATTERN, "a");
        add_item(KIND_TEXT, "a");
        add_item(KIND_TEXT, "b");
        add_item(KIND_TEXT, "a");
        add_item(KIND_TEXT, "b");
        add_item(KIND_TEXT, "a");
        add_item(KIND_RESTART, 8'h5A);
        add_item(KIND_TEXT, "a");
        add_item(KIND_TEXT, "b");
        add_item(KIND_TEXT, "a");
        // pattern grows while text is in flight
        add_item(KIND_PATTERN, "b");
        add_item(KIND_TEXT, "b");
        add_item(KIND_CLEAR, 8'hA5);
        add_item(KIND_PATTERN, 8'hFF);
        add_item(KIND_PATTERN, 8'h00);
        add_item(KIND_TEXT, 8'hFF);
        add_item(KIND_TEXT, 8'h00);
        add_item(KIND_TEXT, 8'hFF);
        add_item(KIND_TEXT, 8'h00);
        add_item(KIND_RESTART, 8'hFF);
        add_item(KIND_CLEAR, 8'h00);

        n = pending_items.size();
        while (pending_items.size() < n + RANDOM_ITEMS) begin
            seq_kind = $urandom_range(0, 11);
            alpha    = $urandom_range(1, 4);
            base     = 8'($urandom_range(0, 252));
            if (seq_kind == 0) begin
                // noise
                repeat ($urandom_range(1, 20))
                    add_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
            end else if (seq_kind == 1) begin
                // fill the store, then overflow it
                add_item(KIND_CLEAR, 8'($urandom_range(0, 255)));
                repeat (MAX_PAT + $urandom_range(1, 3))
                    add_item(KIND_PATTERN, 8'(base + $urandom_range(0, 1)));
                repeat ($urandom_range(10, 40))
                    add_item(KIND_TEXT, 8'(base + $urandom_range(0, 1)));
            end else if (seq_kind == 2) begin
                // empty pattern
                add_item(KIND_CLEAR, 8'($urandom_range(0, 255)));
                repeat ($urandom_range(1, 8))
                    add_item(KIND_TEXT, 8'($urandom_range(0, 255)));
            end else begin
                if ($urandom_range(0, 3) == 0 && seq_kind > 8) begin
                    add_item(KIND_RESTART, 8'($urandom_range(0, 255)));
                end else begin
                    add_item(KIND_CLEAR, 8'($urandom_range(0, 255)));
                    plen = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24)
                                                       : $urandom_range(1, 8);
                    repeat (plen)
                        add_item(KIND_PATTERN, 8'(base + $urandom_range(0, alpha - 1)));
                end
                tlen = $urandom_range(10, 60);
                repeat (tlen) begin
                    case ($urandom_range(0, 39))
                        0: add_item(KIND_RESTART, 8'($urandom_range(0, 255)));
                        1: add_item(KIND_PATTERN, 8'(base + $urandom_range(0, alpha - 1)));
                        2: add_item(KIND_TEXT, 8'($urandom_range(0, 255)));
                        default: add_item(KIND_TEXT, 8'(base + $urandom_range(0, alpha - 1)));
                    endcase
                end
            end
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (expected_results.size() != 0) begin
            $error("%0d expected results never arrived", expected_results.size());
            errors++;
        end
        $display("Sent %0d items (patterns, text, clears, restarts); checked %0d results,",
                 items_sent, results_checked);
        $display("%0d of them matches and %0d dropped pattern bytes; %0d mismatches.",
                 matches_seen, drops_seen, errors);
        if (errors == 0) begin
            $display("** kmp_stream_matcher: PASSED **");
        end else begin
            $display("** kmp_stream_matcher: FAILED **");
        end
        $finish;
    end

endmodule
